@@ rtl/c3f_pkg.sv @@
// Shared constants, types and helpers for the 3x3 convolution filter.
package c3f_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int COORD_W    = 10;
   localparam int SIZE_W     = 11;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 8;
   localparam int ROW_REG_W  = 3 * COEF_W;
   localparam int PROD_W     = PIX_W + COEF_W + 1;
   localparam int PSUM_W     = PROD_W + 1;
   localparam int SUM_W      = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ROW_REG_W;
   localparam int MIN_SIZE   = 3;

   localparam logic [ROW_REG_W-1:0] COEFF_RESET = ROW_REG_W'(24'hFF0001);
   localparam logic [SIZE_W-1:0]    SIZE_RESET  = SIZE_W'(6);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEFF_TOP    = 3'd0,
      CSR_COEFF_MID    = 3'd1,
      CSR_COEFF_BOT    = 3'd2,
      CSR_FRAME_WIDTH  = 3'd3,
      CSR_FRAME_HEIGHT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] filtered;
      logic [COORD_W-1:0]      out_row;
      logic [COORD_W-1:0]      out_col;
      logic                    frame_last;
   } rsp_type;

   typedef struct packed {
      logic [ROW_REG_W-1:0] coeff_top;
      logic [ROW_REG_W-1:0] coeff_mid;
      logic [ROW_REG_W-1:0] coeff_bot;
      logic [COORD_W-1:0]   w_m1;
      logic [COORD_W-1:0]   h_m1;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic               emit;
      logic               last;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   px;
      logic [PIX_W-1:0]   mid;
      logic [PIX_W-1:0]   top;
   } win_col_type;

   function automatic logic signed [COEF_W-1:0] coeff_at(input logic [ROW_REG_W-1:0] row_reg,
                                                         input int k);
      return $signed(row_reg[k*COEF_W +: COEF_W]);
   endfunction

endpackage

@@ rtl/c3f_csr.sv @@
// Configuration registers with frame size clamping.
module c3f_csr import c3f_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [ROW_REG_W-1:0] coeff_top_ff;
   logic [ROW_REG_W-1:0] coeff_mid_ff;
   logic [ROW_REG_W-1:0] coeff_bot_ff;
   logic [SIZE_W-1:0]    width_ff;
   logic [SIZE_W-1:0]    height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_top_ff <= COEFF_RESET;
         coeff_mid_ff <= COEFF_RESET;
         coeff_bot_ff <= COEFF_RESET;
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COEFF_TOP:    coeff_top_ff <= csr_wdata;
            CSR_COEFF_MID:    coeff_mid_ff <= csr_wdata;
            CSR_COEFF_BOT:    coeff_bot_ff <= csr_wdata;
            CSR_FRAME_WIDTH:  width_ff     <= csr_wdata[SIZE_W-1:0];
            CSR_FRAME_HEIGHT: height_ff    <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.coeff_top = coeff_top_ff;
      cfg.coeff_mid = coeff_mid_ff;
      cfg.coeff_bot = coeff_bot_ff;
      if (width_ff < SIZE_W'(MIN_SIZE)) begin
         cfg.w_m1 = COORD_W'(MIN_SIZE - 1);
      end else if (width_ff > SIZE_W'(MAX_WIDTH)) begin
         cfg.w_m1 = COORD_W'(MAX_WIDTH - 1);
      end else begin
         cfg.w_m1 = COORD_W'(width_ff - SIZE_W'(1));
      end
      if (height_ff < SIZE_W'(MIN_SIZE)) begin
         cfg.h_m1 = COORD_W'(MIN_SIZE - 1);
      end else if (height_ff > SIZE_W'(MAX_HEIGHT)) begin
         cfg.h_m1 = COORD_W'(MAX_HEIGHT - 1);
      end else begin
         cfg.h_m1 = COORD_W'(height_ff - SIZE_W'(1));
      end
   end

endmodule

@@ rtl/c3f_line_buf.sv @@
// Position counters, two line stores and the column fetch stage.
module c3f_line_buf import c3f_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   input  logic        pop,
   output win_col_type s1
);

   logic [PIX_W-1:0] mem_a [MAX_WIDTH];
   logic [PIX_W-1:0] mem_b [MAX_WIDTH];

   logic [COORD_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_emit_ff;
   logic               s1_last_ff;
   logic [COORD_W-1:0] s1_row_ff;
   logic [COORD_W-1:0] s1_col_ff;
   logic [PIX_W-1:0]   s1_px_ff;
   logic [PIX_W-1:0]   rd_a_ff;
   logic [PIX_W-1:0]   rd_b_ff;
   logic               byp_ff;
   logic [PIX_W-1:0]   byp_a_ff;
   logic [PIX_W-1:0]   byp_b_ff;

   logic               accept;
   logic [COORD_W-1:0] col_cur;
   logic [COORD_W-1:0] row_cur;
   logic               emit_cur;
   logic               last_cur;
   logic [PIX_W-1:0]   mid_cur;
   logic [PIX_W-1:0]   top_cur;

   assign req_ready = !s1_valid_ff || pop;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_cur  = req_data.frame_start ? '0 : col_ff;
      row_cur  = req_data.frame_start ? '0 : row_ff;
      emit_cur = (row_cur >= COORD_W'(2)) && (col_cur >= COORD_W'(2)) &&
                 (row_cur <= cfg.h_m1) && (col_cur <= cfg.w_m1);
      last_cur = (row_cur == cfg.h_m1) && (col_cur == cfg.w_m1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_cur >= cfg.w_m1) begin
            col_in = '0;
            row_in = (row_cur >= cfg.h_m1) ? '0 : row_cur + COORD_W'(1);
         end else begin
            col_in = col_cur + COORD_W'(1);
            row_in = row_cur;
         end
      end
      s1_valid_in = accept ? 1'b1 : (pop ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // forward the line store write that lands on the address being read
   assign mid_cur = byp_ff ? byp_a_ff : rd_a_ff;
   assign top_cur = byp_ff ? byp_b_ff : rd_b_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         mem_a[s1_col_ff[ADDR_W-1:0]] <= s1_px_ff;
         mem_b[s1_col_ff[ADDR_W-1:0]] <= mid_cur;
      end
      if (accept) begin
         rd_a_ff <= mem_a[col_cur[ADDR_W-1:0]];
         rd_b_ff <= mem_b[col_cur[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff <= emit_cur;
         s1_last_ff <= last_cur;
         s1_row_ff  <= row_cur;
         s1_col_ff  <= col_cur;
         s1_px_ff   <= req_data.pixel;
         byp_ff     <= pop && (col_cur == s1_col_ff);
         byp_a_ff   <= s1_px_ff;
         byp_b_ff   <= mid_cur;
      end
   end

   always_comb begin
      s1.valid = s1_valid_ff;
      s1.emit  = s1_emit_ff;
      s1.last  = s1_last_ff;
      s1.row   = s1_row_ff;
      s1.col   = s1_col_ff;
      s1.px    = s1_px_ff;
      s1.mid   = mid_cur;
      s1.top   = top_cur;
   end

   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.frame_start |=> s1_col_ff == '0 && s1_row_ff == '0)
      else $error("frame start did not restart position");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transfer lost in fetch stage");

endmodule

@@ rtl/c3f_mac.sv @@
// Window registers, nine products, adder tree and result register.
module c3f_mac import c3f_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  win_col_type s1,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   logic [PIX_W-1:0]         window_ff [3][3];
   logic [PIX_W-1:0]         window_in [3][3];
   logic [ROW_REG_W-1:0]     coeff_rows [3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PSUM_W-1:0] psum_in [3];
   logic signed [PSUM_W-1:0] psum_ff [3];
   logic signed [SUM_W-1:0]  sum_in;

   logic               s2_valid_ff, s2_valid_in;
   logic [COORD_W-1:0] s2_row_ff, s2_col_ff;
   logic               s2_last_ff;
   logic               s3_valid_ff, s3_valid_in;
   logic [COORD_W-1:0] s3_row_ff, s3_col_ff;
   logic               s3_last_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff;

   logic rdy_o, rdy_3, rdy_2;

   assign rdy_o = !out_valid_ff || rsp_ready;
   assign rdy_3 = !s3_valid_ff || rdy_o;
   assign rdy_2 = !s2_valid_ff || rdy_3;
   assign pop   = s1.valid && rdy_2;

   always_comb begin
      coeff_rows[0] = cfg.coeff_top;
      coeff_rows[1] = cfg.coeff_mid;
      coeff_rows[2] = cfg.coeff_bot;
      for (int r = 0; r < 3; r++) begin
         window_in[r][0] = window_ff[r][1];
         window_in[r][1] = window_ff[r][2];
      end
      window_in[0][2] = s1.top;
      window_in[1][2] = s1.mid;
      window_in[2][2] = s1.px;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed({1'b0, window_in[r][c]}) * coeff_at(coeff_rows[r], c);
         end
      end
      for (int r = 0; r < 3; r++) begin
         psum_in[r] = PSUM_W'(prod_ff[r][0]) + PSUM_W'(prod_ff[r][1]) + PSUM_W'(prod_ff[r][2]);
      end
      sum_in = SUM_W'(psum_ff[0]) + SUM_W'(psum_ff[1]) + SUM_W'(psum_ff[2]);
      s2_valid_in  = rdy_2 ? (s1.valid && s1.emit) : s2_valid_ff;
      s3_valid_in  = rdy_3 ? s2_valid_ff : s3_valid_ff;
      out_valid_in = rdy_o ? s3_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               window_ff[r][c] <= '0;
            end
         end
      end else if (pop) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_2) begin
         prod_ff    <= prod_in;
         s2_row_ff  <= s1.row - COORD_W'(1);
         s2_col_ff  <= s1.col - COORD_W'(1);
         s2_last_ff <= s1.last;
      end
      if (rdy_3) begin
         psum_ff    <= psum_in;
         s3_row_ff  <= s2_row_ff;
         s3_col_ff  <= s2_col_ff;
         s3_last_ff <= s2_last_ff;
      end
      if (rdy_o) begin
         out_ff.filtered   <= sum_in;
         out_ff.out_row    <= s3_row_ff;
         out_ff.out_col    <= s3_col_ff;
         out_ff.frame_last <= s3_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_emit_reaches_products: assert property (@(posedge clock) disable iff (reset)
      s1.valid && s1.emit && rdy_2 |=> s2_valid_ff)
      else $error("interior position dropped before product stage");

   a_result_from_sum_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s3_valid_ff))
      else $error("result appeared without a summed transfer");

endmodule

@@ rtl/conv3x3_image_filter.sv @@
// Top level of the streaming 3x3 convolution filter.
//
//   channel  ports                         direction  handshake
//   request  req_valid/req_ready/req_data  in         valid/ready transfer
//   response rsp_valid/rsp_ready/rsp_data  out        valid/ready transfer
//   config   csr_we/csr_index/csr_wdata    in         write on csr_we
//
// One pixel transfer per cycle while req_ready is high; a result passes through
// the line store read, products, row sums and final sum into the result register.
// Reset clears counters, window and stage valids; line stores are not cleared.
// A stalled response fills the result register and the sum, product and fetch stages before req_ready drops.
module conv3x3_image_filter import c3f_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg;
   win_col_type s1;
   logic        pop;

   c3f_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   c3f_line_buf u_line_buf (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .pop       (pop),
      .s1        (s1)
   );

   c3f_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .s1        (s1),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
